// File: rtl/core/dnc_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// dnc_pkg - shared types and constants of the date / day number converter
// Holds the day count request/response words, range limits, reciprocal
// constants and the month offset table.
// ----------------------------------------------------------------------------
package dnc_pkg;

    // Command codes
    localparam logic CMD_TO_DAYNUM = 1'b0;
    localparam logic CMD_TO_DATE   = 1'b1;

    // Accepted ranges
    localparam logic [11:0] YEAR_LO = 12'd1700;
    localparam logic [11:0] YEAR_HI = 12'd2500;
    localparam logic [19:0] DN_LO   = 20'd630000;
    localparam logic [19:0] DN_HI   = 20'd913106;

    localparam logic [3:0]  MONTH_FIRST = 4'd1;
    localparam logic [3:0]  MONTH_LAST  = 4'd12;
    localparam logic [4:0]  DAY_FIRST   = 5'd1;

    // Day count arithmetic
    localparam logic [8:0]  DAYS_PER_YEAR = 9'd365;
    // floor(x / 100) = (x * RECIP_100) >> RECIP_100_SHIFT for 12-bit x
    localparam logic [12:0] RECIP_100       = 13'd5243;
    localparam int          RECIP_100_SHIFT = 19;
    // floor(x / 365) = (x * RECIP_365) >> RECIP_365_SHIFT for 20-bit x
    localparam logic [19:0] RECIP_365       = 20'd735440;
    localparam int          RECIP_365_SHIFT = 28;

    // Request to the day count unit
    typedef struct packed {
        logic        valid;
        logic [3:0]  month;
        logic [4:0]  day;
        logic [11:0] year;
    } t_dc_req;

    // Response of the day count unit
    typedef struct packed {
        logic        valid;
        logic [19:0] day_count;
    } t_dc_res;

    // Days before the first of each month in a common year (index = month - 1)
    function automatic logic [8:0] month_offset(input logic [3:0] mi);
        logic [8:0] v;
        begin
            unique case (mi)
                4'd0:    v = 9'd0;
                4'd1:    v = 9'd31;
                4'd2:    v = 9'd59;
                4'd3:    v = 9'd90;
                4'd4:    v = 9'd120;
                4'd5:    v = 9'd151;
                4'd6:    v = 9'd181;
                4'd7:    v = 9'd212;
                4'd8:    v = 9'd243;
                4'd9:    v = 9'd273;
                4'd10:   v = 9'd304;
                default: v = 9'd334;
            endcase
            return v;
        end
    endfunction

endpackage

// File: rtl/core/dnc_in_if.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// dnc_in_if - command channel of the converter
// Valid/ready channel carrying one conversion request word.
// ----------------------------------------------------------------------------
interface dnc_in_if;
    logic        valid;
    logic        ready;
    logic        cmd;
    logic [3:0]  month_in;
    logic [4:0]  day_in;
    logic [11:0] year_in;
    logic [19:0] day_number_in;

    modport source (
        output valid, cmd, month_in, day_in, year_in, day_number_in,
        input  ready
    );

    modport sink (
        input  valid, cmd, month_in, day_in, year_in, day_number_in,
        output ready
    );
endinterface

// File: rtl/core/dnc_out_if.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// dnc_out_if - result channel of the converter
// Valid/ready channel carrying one conversion result word.
// ----------------------------------------------------------------------------
interface dnc_out_if;
    logic        valid;
    logic        ready;
    logic [19:0] day_number_out;
    logic [3:0]  month_out;
    logic [4:0]  day_out;
    logic [11:0] year_out;
    logic        valid_res;

    modport source (
        output valid, day_number_out, month_out, day_out, year_out, valid_res,
        input  ready
    );

    modport sink (
        input  valid, day_number_out, month_out, day_out, year_out, valid_res,
        output ready
    );
endinterface

// File: rtl/core/date_day_number_converter_core.sv
`timescale 1ns / 1ps
// Date to day number is one pass of the day count unit; day number to date is
// one pass per year probe and per month probe. Out-of-range words go straight
// to the finish state. Each probe is one pass of the two-stage day count unit;
// one word is in flight, so the next word is accepted in the cycle after the
// result loads, later while a full result register waits for ready.
// Reset clears the sequencer and the result valid flag; no memories to clear.
// ----------------------------------------------------------------------------
// date_day_number_converter_core - Gregorian date / day number converter
// Sequencer that drives one shared day count unit for both directions: a
// single pass for date to day number, a year then month search for the
// reverse direction.
// ----------------------------------------------------------------------------
module date_day_number_converter_core (
    input  logic      i_clk,
    input  logic      i_rst_n,
    dnc_in_if.sink    i_in,
    dnc_out_if.source o_out
);

    typedef enum logic [8:0] {
        S_IDLE        = 9'b000000001,
        S_QUOT        = 9'b000000010,
        S_YEAR_ISSUE  = 9'b000000100,
        S_YEAR_WAIT   = 9'b000001000,
        S_MONTH_ISSUE = 9'b000010000,
        S_MONTH_WAIT  = 9'b000100000,
        S_FWD_ISSUE   = 9'b001000000,
        S_FWD_WAIT    = 9'b010000000,
        S_FINISH      = 9'b100000000
    } t_state;

    localparam int QW = 40;

    t_state r_state, n_state;
    logic        r_cmd,   n_cmd;
    logic        r_ok,    n_ok;
    logic [19:0] r_j,     n_j;
    logic [3:0]  r_month, n_month;
    logic [4:0]  r_day,   n_day;
    logic [11:0] r_year,  n_year;
    logic [19:0] r_dn,    n_dn;
    logic [4:0]  r_da,    n_da;

    logic        r_out_valid, n_out_valid;
    logic [19:0] r_o_dn, n_o_dn;
    logic [3:0]  r_o_mo, n_o_mo;
    logic [4:0]  r_o_da, n_o_da;
    logic [11:0] r_o_yr, n_o_yr;
    logic        r_o_ok, n_o_ok;

    dnc_pkg::t_dc_req w_req;
    dnc_pkg::t_dc_res w_res;

    logic          w_accept;
    logic          w_fwd_ok;
    logic          w_rev_ok;
    logic [QW-1:0] w_yq_prod;
    logic [11:0]   w_yq;
    logic          w_dc_over;
    logic [19:0]   w_da_full;
    logic          w_out_free;

    // Shared day count unit
    dnc_day_count_unit u_day_count (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_req   (w_req),
        .o_res   (w_res)
    );

    assign w_req.valid = (r_state == S_YEAR_ISSUE) || (r_state == S_MONTH_ISSUE)
                      || (r_state == S_FWD_ISSUE);
    assign w_req.month = r_month;
    assign w_req.day   = r_day;
    assign w_req.year  = r_year;

    // Input handshake and range checks
    assign i_in.ready = (r_state == S_IDLE);
    assign w_accept   = i_in.valid && i_in.ready;

    assign w_fwd_ok = (i_in.month_in >= dnc_pkg::MONTH_FIRST)
                   && (i_in.month_in <= dnc_pkg::MONTH_LAST)
                   && (i_in.day_in >= dnc_pkg::DAY_FIRST)
                   && (i_in.year_in >= dnc_pkg::YEAR_LO)
                   && (i_in.year_in <= dnc_pkg::YEAR_HI);
    assign w_rev_ok = (i_in.day_number_in >= dnc_pkg::DN_LO)
                   && (i_in.day_number_in <= dnc_pkg::DN_HI);

    // Starting year guess: day number / 365 by reciprocal
    assign w_yq_prod = QW'(r_j) * QW'(dnc_pkg::RECIP_365);
    assign w_yq      = w_yq_prod[dnc_pkg::RECIP_365_SHIFT +: 12];

    assign w_dc_over  = (w_res.day_count > r_j);
    assign w_da_full  = r_j - w_res.day_count + 20'd1;
    assign w_out_free = !r_out_valid || o_out.ready;

    // Sequencer
    always_comb begin
        n_state     = r_state;
        n_cmd       = r_cmd;
        n_ok        = r_ok;
        n_j         = r_j;
        n_month     = r_month;
        n_day       = r_day;
        n_year      = r_year;
        n_dn        = r_dn;
        n_da        = r_da;
        n_out_valid = r_out_valid && !o_out.ready;
        n_o_dn      = r_o_dn;
        n_o_mo      = r_o_mo;
        n_o_da      = r_o_da;
        n_o_yr      = r_o_yr;
        n_o_ok      = r_o_ok;

        unique case (r_state)
            S_IDLE: begin
                if (w_accept) begin
                    n_cmd = i_in.cmd;
                    n_j   = i_in.day_number_in;
                    if (i_in.cmd == dnc_pkg::CMD_TO_DAYNUM) begin
                        n_month = i_in.month_in;
                        n_day   = i_in.day_in;
                        n_year  = i_in.year_in;
                        n_ok    = w_fwd_ok;
                        n_state = w_fwd_ok ? S_FWD_ISSUE : S_FINISH;
                    end else begin
                        n_month = dnc_pkg::MONTH_FIRST;
                        n_day   = dnc_pkg::DAY_FIRST;
                        n_ok    = w_rev_ok;
                        n_state = w_rev_ok ? S_QUOT : S_FINISH;
                    end
                end
            end
            S_QUOT: begin
                n_year  = (w_yq > dnc_pkg::YEAR_HI) ? dnc_pkg::YEAR_HI : w_yq;
                n_state = S_YEAR_ISSUE;
            end
            S_YEAR_ISSUE: begin
                n_state = S_YEAR_WAIT;
            end
            S_YEAR_WAIT: begin
                // Step the year down while January 1 lies past the day number
                if (w_res.valid) begin
                    if ((r_year > dnc_pkg::YEAR_LO) && w_dc_over) begin
                        n_year  = r_year - 12'd1;
                        n_state = S_YEAR_ISSUE;
                    end else begin
                        n_month = dnc_pkg::MONTH_LAST;
                        n_state = S_MONTH_ISSUE;
                    end
                end
            end
            S_MONTH_ISSUE: begin
                n_state = S_MONTH_WAIT;
            end
            S_MONTH_WAIT: begin
                // Step the month down, then take the day as the remainder
                if (w_res.valid) begin
                    if ((r_month > dnc_pkg::MONTH_FIRST) && w_dc_over) begin
                        n_month = r_month - 4'd1;
                        n_state = S_MONTH_ISSUE;
                    end else begin
                        n_da    = w_da_full[4:0];
                        n_state = S_FINISH;
                    end
                end
            end
            S_FWD_ISSUE: begin
                n_state = S_FWD_WAIT;
            end
            S_FWD_WAIT: begin
                if (w_res.valid) begin
                    n_dn    = w_res.day_count;
                    n_state = S_FINISH;
                end
            end
            S_FINISH: begin
                // Load the output word once the previous one is gone
                if (w_out_free) begin
                    n_out_valid = 1'b1;
                    n_o_ok      = r_ok;
                    if (r_ok && (r_cmd == dnc_pkg::CMD_TO_DAYNUM)) begin
                        n_o_dn = r_dn;
                    end else begin
                        n_o_dn = 20'd0;
                    end
                    if (r_ok && (r_cmd == dnc_pkg::CMD_TO_DATE)) begin
                        n_o_mo = r_month;
                        n_o_da = r_da;
                        n_o_yr = r_year;
                    end else begin
                        n_o_mo = 4'd0;
                        n_o_da = 5'd0;
                        n_o_yr = 12'd0;
                    end
                    n_state = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    // Control registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_out_valid <= n_out_valid;
        end
    end

    // Payload registers
    always_ff @(posedge i_clk) begin
        r_cmd   <= n_cmd;
        r_ok    <= n_ok;
        r_j     <= n_j;
        r_month <= n_month;
        r_day   <= n_day;
        r_year  <= n_year;
        r_dn    <= n_dn;
        r_da    <= n_da;
        r_o_dn  <= n_o_dn;
        r_o_mo  <= n_o_mo;
        r_o_da  <= n_o_da;
        r_o_yr  <= n_o_yr;
        r_o_ok  <= n_o_ok;
    end

    assign o_out.valid          = r_out_valid;
    assign o_out.day_number_out = r_o_dn;
    assign o_out.month_out      = r_o_mo;
    assign o_out.day_out        = r_o_da;
    assign o_out.year_out       = r_o_yr;
    assign o_out.valid_res      = r_o_ok;

    // Unit results only arrive while the sequencer waits for them
    a_res_in_wait: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_res.valid |-> (r_state == S_YEAR_WAIT || r_state == S_MONTH_WAIT
                      || r_state == S_FWD_WAIT))
        else $error("day count result outside a wait state");

    // An accepted word always starts work
    a_accept_leaves_idle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_accept |=> (r_state != S_IDLE))
        else $error("accepted word did not leave idle");

    // The month search runs on a year inside the accepted range
    a_year_in_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_MONTH_ISSUE) |-> (r_year >= dnc_pkg::YEAR_LO
                                     && r_year <= dnc_pkg::YEAR_HI))
        else $error("month search year out of range");

    // An invalid result carries all-zero fields
    a_invalid_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_out_valid && !r_o_ok) |-> (r_o_dn == 20'd0 && r_o_mo == 4'd0
                                   && r_o_da == 5'd0 && r_o_yr == 12'd0))
        else $error("invalid result with nonzero fields");

endmodule

// File: rtl/core/dnc_day_count_unit.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// dnc_day_count_unit - two-stage Gregorian day count
// Turns month/day/year into the day count from January 1 of year one.
// Stage one forms the products and quotients, stage two sums them.
// ----------------------------------------------------------------------------
module dnc_day_count_unit (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  dnc_pkg::t_dc_req i_req,
    output dnc_pkg::t_dc_res o_res
);

    localparam int QW = 25;

    logic [11:0] w_p;
    logic [20:0] w_p365;
    logic [QW-1:0] w_qp_prod;
    logic [QW-1:0] w_qy_prod;
    logic [3:0]  w_mi;
    logic [9:0]  w_offd;

    logic        r1_valid;
    logic [20:0] r1_p365;
    logic [9:0]  r1_p4;
    logic [5:0]  r1_qp;
    logic [5:0]  r1_qy;
    logic [9:0]  r1_offd;
    logic        r1_leap_cand;

    logic        w_leap;
    logic [20:0] w_sum;

    logic        r2_valid;
    logic [19:0] r2_dc;

    // Stage one: year products, century quotients, month offset
    assign w_p       = i_req.year - 12'd1;
    assign w_p365    = 21'(w_p) * 21'(dnc_pkg::DAYS_PER_YEAR);
    assign w_qp_prod = QW'(w_p) * QW'(dnc_pkg::RECIP_100);
    assign w_qy_prod = QW'(i_req.year) * QW'(dnc_pkg::RECIP_100);

    // Clamp the month index the way an out-of-range month wraps
    assign w_mi = (i_req.month == 4'd0 || i_req.month > dnc_pkg::MONTH_LAST)
                  ? 4'd11 : (i_req.month - 4'd1);
    assign w_offd = 10'(dnc_pkg::month_offset(w_mi)) + 10'(i_req.day);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r1_valid <= 1'b0;
        end else begin
            r1_valid <= i_req.valid;
        end
    end

    always_ff @(posedge i_clk) begin
        r1_p365      <= w_p365;
        r1_p4        <= w_p[11:2];
        r1_qp        <= w_qp_prod[dnc_pkg::RECIP_100_SHIFT +: 6];
        r1_qy        <= w_qy_prod[dnc_pkg::RECIP_100_SHIFT +: 6];
        r1_offd      <= w_offd;
        r1_leap_cand <= (i_req.year[1:0] == 2'b00) && (i_req.month > 4'd2);
    end

    // Stage two: a century year is leap only when its century count is a
    // multiple of four; year/100 differs from (year-1)/100 only on centuries
    assign w_leap = r1_leap_cand && ((r1_qy == r1_qp) || (r1_qy[1:0] == 2'b00));
    assign w_sum  = r1_p365 + 21'(r1_p4) + 21'(r1_qp[5:2]) + 21'(r1_offd)
                  + 21'(w_leap) - 21'(r1_qp);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r2_valid <= 1'b0;
        end else begin
            r2_valid <= r1_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        r2_dc <= w_sum[19:0];
    end

    assign o_res.valid     = r2_valid;
    assign o_res.day_count = r2_dc;

endmodule

// File: dv/date_day_number_converter_core_tb.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// date_day_number_converter_core_tb - self-checking bench of the converter
// Drives date and day number words through the valid/ready channels with
// random gaps and a long result stall, predicts each conversion in a
// scoreboard and compares every result word field by field.
// ----------------------------------------------------------------------------
module date_day_number_converter_core_tb;

    localparam int RANDOM_WORDS = 600;
    localparam int DRAIN_CYCLES = 60;
    localparam int STALL_AFTER  = 400;
    localparam int STALL_CYCLES = 500;

    // Offset of each month start beyond 30 days per month, common year
    localparam int MONTH_BIAS [12] = '{0, 1, -1, 0, 0, 1, 1, 2, 3, 3, 4, 4};

    typedef struct {
        bit        cmd;
        bit [3:0]  month;
        bit [4:0]  day;
        bit [11:0] year;
        bit [19:0] day_number;
    } t_conv_request;

    typedef struct {
        bit [19:0] day_number;
        bit [3:0]  month;
        bit [4:0]  day;
        bit [11:0] year;
        bit        in_range;
    } t_conv_result;

    // ------------------------------------------------------------------------
    // Scoreboard: predict each accepted word, check results in order
    // ------------------------------------------------------------------------
    class t_conversion_scoreboard;
        t_conv_result pending_results[$];
        int accepted;
        int to_daynum_words;
        int to_date_words;
        int rejected_words;
        int checked;
        int mismatches;

        function new();
            accepted = 0;
            to_daynum_words = 0;
            to_date_words = 0;
            rejected_words = 0;
            checked = 0;
            mismatches = 0;
        endfunction

        function automatic bit leap_year(int unsigned y);
            return ((y % 4 == 0) && (y % 100 != 0)) || (y % 400 == 0);
        endfunction

        // Day count from January 1 of year one for an in-range date
        function automatic int unsigned days_since_epoch(int unsigned m, int unsigned d,
                                                         int unsigned y);
            int unsigned prev;
            int unsigned mi;
            int total;
            prev = y - 1;
            mi = (m - 1) & 4'hF;
            if (mi > 11) mi = 11;
            total = int'(prev * 365 + prev / 4 - prev / 100 + prev / 400);
            total += MONTH_BIAS[mi] + int'(mi * 30) + int'(d);
            if (leap_year(y) && m > 2) total += 1;
            return int'(total);
        endfunction

        function automatic t_conv_result predict_conversion(t_conv_request w);
            t_conv_result r;
            int unsigned yr;
            int unsigned mo;
            r = '{default: '0};
            if (w.cmd == dnc_pkg::CMD_TO_DAYNUM) begin
                if (w.month >= dnc_pkg::MONTH_FIRST && w.month <= dnc_pkg::MONTH_LAST &&
                    w.day >= dnc_pkg::DAY_FIRST &&
                    w.year >= dnc_pkg::YEAR_LO && w.year <= dnc_pkg::YEAR_HI) begin
                    r.day_number = 20'(days_since_epoch(w.month, w.day, w.year));
                    r.in_range = 1'b1;
                end
            end else if (w.day_number >= dnc_pkg::DN_LO && w.day_number <= dnc_pkg::DN_HI) begin
                // Step the year down, then the month down, then count the day
                yr = w.day_number / 365;
                if (yr > dnc_pkg::YEAR_HI) yr = dnc_pkg::YEAR_HI;
                while (yr > dnc_pkg::YEAR_LO && days_since_epoch(1, 1, yr) > w.day_number)
                    yr--;
                mo = 12;
                while (mo > 1 && days_since_epoch(mo, 1, yr) > w.day_number) mo--;
                r.month = 4'(mo);
                r.day = 5'(w.day_number - days_since_epoch(mo, 1, yr) + 1);
                r.year = 12'(yr);
                r.in_range = 1'b1;
            end
            return r;
        endfunction

        function void note_request(t_conv_request w);
            t_conv_result r;
            r = predict_conversion(w);
            pending_results.push_back(r);
            accepted++;
            if (w.cmd == dnc_pkg::CMD_TO_DAYNUM) to_daynum_words++;
            else to_date_words++;
            if (!r.in_range) rejected_words++;
        endfunction

        function void check_result(t_conv_result got);
            t_conv_result exp;
            if (pending_results.size() == 0) begin
                $error("unexpected result word: day_number_out %0d", got.day_number);
                mismatches++;
                return;
            end
            exp = pending_results.pop_front();
            checked++;
            if (got.day_number !== exp.day_number) begin
                $error("day_number_out: expected %0d, actual %0d", exp.day_number,
                       got.day_number);
                mismatches++;
            end
            if (got.month !== exp.month) begin
                $error("month_out: expected %0d, actual %0d", exp.month, got.month);
                mismatches++;
            end
            if (got.day !== exp.day) begin
                $error("day_out: expected %0d, actual %0d", exp.day, got.day);
                mismatches++;
            end
            if (got.year !== exp.year) begin
                $error("year_out: expected %0d, actual %0d", exp.year, got.year);
                mismatches++;
            end
            if (got.in_range !== exp.in_range) begin
                $error("valid_res: expected %0d, actual %0d", exp.in_range, got.in_range);
                mismatches++;
            end
        endfunction
    endclass

    logic i_clk;
    logic i_rst_n;
    bit   quiet_phase;

    dnc_in_if  in_if ();
    dnc_out_if out_if ();

    t_conversion_scoreboard conv_sb = new();

    date_day_number_converter_core DUT (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_in    (in_if),
        .o_out   (out_if)
    );

    // Free-running clock
    initial begin
        i_clk = 1'b0;
        forever #6 i_clk = ~i_clk;
    end

    // Hard stop in case the block hangs
    initial begin
        #5000000;
        $display("end of test: mismatches");
        $finish;
    end

    // ------------------------------------------------------------------------
    // Word builders with random content in the unused fields
    // ------------------------------------------------------------------------
    function automatic t_conv_request date_word(int unsigned m, int unsigned d, int unsigned y);
        t_conv_request w;
        w.cmd = dnc_pkg::CMD_TO_DAYNUM;
        w.month = 4'(m);
        w.day = 5'(d);
        w.year = 12'(y);
        w.day_number = 20'($urandom_range(20'hFFFFF, 0));
        return w;
    endfunction

    function automatic t_conv_request daynum_word(int unsigned j);
        t_conv_request w;
        w.cmd = dnc_pkg::CMD_TO_DATE;
        w.month = 4'($urandom_range(15, 0));
        w.day = 5'($urandom_range(31, 0));
        w.year = 12'($urandom_range(4095, 0));
        w.day_number = 20'(j);
        return w;
    endfunction

    // Offer one word, idle at random first, and wait for acceptance
    task automatic send_word(input t_conv_request w);
        while (!quiet_phase && $urandom_range(99, 0) < 15) begin
            in_if.valid <= 1'b0;
            @(posedge i_clk);
        end
        in_if.valid         <= 1'b1;
        in_if.cmd           <= w.cmd;
        in_if.month_in      <= w.month;
        in_if.day_in        <= w.day;
        in_if.year_in       <= w.year;
        in_if.day_number_in <= w.day_number;
        @(posedge i_clk);
        while (!in_if.ready) @(posedge i_clk);
        conv_sb.note_request(w);
    endtask

    task automatic run_directed();
        // Range edges and out-of-range fields of the date direction
        send_word(date_word(1, 1, 1700));
        send_word(date_word(12, 31, 2500));
        send_word(date_word(0, 15, 2000));
        send_word(date_word(13, 1, 2000));
        send_word(date_word(15, 31, 4095));
        send_word(date_word(6, 0, 2000));
        send_word(date_word(6, 31, 1699));
        send_word(date_word(1, 1, 2501));
        send_word(date_word(0, 0, 0));
        // Leap rules and a day past the month length
        send_word(date_word(2, 29, 2000));
        send_word(date_word(3, 1, 1900));
        send_word(date_word(2, 31, 2100));
        send_word(date_word(12, 31, 1999));
        // Range edges of the day number direction and the top of the range
        send_word(daynum_word(0));
        send_word(daynum_word(629999));
        send_word(daynum_word(630000));
        send_word(daynum_word(913106));
        send_word(daynum_word(913107));
        send_word(daynum_word(1048575));
        send_word(daynum_word(912864));
        send_word(daynum_word(912865));
        send_word(daynum_word(730120));
        send_word(daynum_word(730485));
    endtask

    task automatic run_random();
        int unsigned roll;
        int unsigned anchor;
        t_conv_request w;
        for (int n = 0; n < RANDOM_WORDS; n++) begin
            // Hold a long stretch without gaps on either side
            quiet_phase = (n >= 150 && n < 300);
            roll = $urandom_range(99, 0);
            if (roll < 40) begin
                w = date_word($urandom_range(12, 1), $urandom_range(31, 1),
                              $urandom_range(dnc_pkg::YEAR_HI, dnc_pkg::YEAR_LO));
            end else if (roll < 50) begin
                w = date_word($urandom_range(15, 0), $urandom_range(31, 0),
                              $urandom_range(4095, 0));
            end else if (roll < 70) begin
                w = daynum_word($urandom_range(dnc_pkg::DN_HI, dnc_pkg::DN_LO));
            end else if (roll < 85) begin
                // Land next to a month or year start to probe the search edges
                anchor = conv_sb.days_since_epoch($urandom_range(12, 1), 1,
                             $urandom_range(dnc_pkg::YEAR_HI, dnc_pkg::YEAR_LO));
                anchor = anchor + $urandom_range(2, 0) - 1;
                if (anchor < dnc_pkg::DN_LO) anchor = dnc_pkg::DN_LO;
                w = daynum_word(anchor);
            end else begin
                w = daynum_word($urandom_range(20'hFFFFF, 0));
            end
            send_word(w);
        end
        quiet_phase = 1'b0;
    endtask

    // ------------------------------------------------------------------------
    // Result side: check accepted words, stall at random and once for long
    // ------------------------------------------------------------------------
    initial begin : result_sink
        int hold_left;
        bit hold_done;
        t_conv_result got;
        hold_left = 0;
        hold_done = 1'b0;
        out_if.ready <= 1'b0;
        forever begin
            @(posedge i_clk);
            if (out_if.valid === 1'b1 && out_if.ready === 1'b1) begin
                got.day_number = out_if.day_number_out;
                got.month      = out_if.month_out;
                got.day        = out_if.day_out;
                got.year       = out_if.year_out;
                got.in_range   = out_if.valid_res;
                conv_sb.check_result(got);
            end
            if (!hold_done && conv_sb.accepted >= STALL_AFTER) begin
                hold_left = STALL_CYCLES;
                hold_done = 1'b1;
            end
            if (!i_rst_n) begin
                out_if.ready <= 1'b0;
            end else if (hold_left > 0) begin
                hold_left--;
                out_if.ready <= 1'b0;
            end else if (quiet_phase) begin
                out_if.ready <= 1'b1;
            end else begin
                out_if.ready <= ($urandom_range(99, 0) >= 15);
            end
        end
    end

    // ------------------------------------------------------------------------
    // Stimulus and end of run
    // ------------------------------------------------------------------------
    initial begin : stimulus
        quiet_phase = 1'b0;
        i_rst_n             <= 1'b0;
        in_if.valid         <= 1'b0;
        in_if.cmd           <= dnc_pkg::CMD_TO_DAYNUM;
        in_if.month_in      <= '0;
        in_if.day_in        <= '0;
        in_if.year_in       <= '0;
        in_if.day_number_in <= '0;
        repeat (2) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        run_directed();
        run_random();
        in_if.valid <= 1'b0;

        // Drain outstanding results, then watch for stray words
        while (conv_sb.pending_results.size() != 0) @(posedge i_clk);
        repeat (DRAIN_CYCLES) @(posedge i_clk);

        $display("covered %0d date to day number and %0d day number to date words",
                 conv_sb.to_daynum_words, conv_sb.to_date_words);
        $display("%0d words out of range, %0d results checked, one long result stall",
                 conv_sb.rejected_words, conv_sb.checked);
        if (conv_sb.mismatches == 0 && conv_sb.pending_results.size() == 0) begin
            $display("end of test: clean");
        end else begin
            $display("end of test: mismatches");
        end
        $finish;
    end

endmodule
